// ===== rtl/core/ptb_pkg.sv =====
package ptb_pkg;

  // Number of timer channels held in the bank.
  localparam int NUM_CHANNELS = 16;

  // Channel index and scan counter widths follow from the channel count.
  localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

  // Fixed field widths of the stream items.
  localparam int ID_W   = 4;
  localparam int TIME_W = 16;
  localparam int PAY_W  = 16;
  localparam int REQ_W  = 3;

  // Request codes carried in the input tuser.
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK          = 3'd0,
    REQ_SCAN          = 3'd1,
    REQ_SET           = 3'd2,
    REQ_SET_IF_ACTIVE = 3'd3,
    REQ_CANCEL        = 3'd4,
    REQ_QUERY         = 3'd5
  } req_e;

  // Response kinds carried in the output tuser.
  typedef enum logic {
    RESP_FIRED = 1'b0,
    RESP_QUERY = 1'b1
  } resp_e;

  // One channel entry of the state memory.
  typedef struct packed {
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] start;
    logic [PAY_W-1:0]  payload;
  } entry_t;

  // Access request from the sequencer to the channel memory.
  typedef struct packed {
    logic            rd_en;
    logic [CH_W-1:0] rd_addr;
    logic            wr_en;
    logic [CH_W-1:0] wr_addr;
    entry_t          wr_data;
  } ram_req_t;

  // One result item.
  typedef struct packed {
    resp_e            kind;
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] payload;
    logic             active;
    logic             last;
  } resp_t;

endpackage

// ===== rtl/core/ptb_chan_ram.sv =====
module ptb_chan_ram (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptb_pkg::ram_req_t req_i,
  output ptb_pkg::entry_t   rd_data_o
);

  ptb_pkg::entry_t                      mem_q [ptb_pkg::NUM_CHANNELS];
  logic [ptb_pkg::NUM_CHANNELS-1:0]     written_q;
  ptb_pkg::entry_t                      rd_data_q;
  logic                                 rd_written_q;

  // Synchronous write and registered read of the channel entries.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  // Per-entry written flags stand in for the cleared period table at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        written_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_written_q <= written_q[req_i.rd_addr];
      end
    end
  end

  // An entry never written reads as an inactive channel.
  always_comb begin
    rd_data_o = rd_data_q;
    if (!rd_written_q) begin
      rd_data_o.period = '0;
    end
  end

endmodule

// ===== rtl/core/ptb_out_reg.sv =====
module ptb_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ptb_pkg::resp_t      data_i,
  output logic                free_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,  // [3:0] fired_id, [19:4] fired_payload,
                                             // [20] is_active, [23:21] zero
  output logic                m_axis_tuser,  // [0] resp_kind
  output logic                m_axis_tlast   // last
);

  logic           vld_q;
  logic           vld_d;
  ptb_pkg::resp_t data_q;

  // The register may be loaded whenever it is empty or being drained.
  assign free_o = !vld_q || m_axis_tready;

  always_comb begin
    vld_d = vld_q;
    if (push_i) begin
      vld_d = 1'b1;
    end else if (m_axis_tready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  // Pack the held result onto the stream.
  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {3'b000, data_q.active, data_q.payload, data_q.id};
  assign m_axis_tuser  = data_q.kind;
  assign m_axis_tlast  = data_q.last;

endmodule

// ===== rtl/core/periodic_timer_bank_top.sv =====
// Bank of channel timers kept against a 16-bit tick count that tick requests advance.
// The input stream carries requests: tuser selects tick, scan, set,
// set-if-active, cancel or query; tdata holds the channel, period and payload.
// The output stream carries fired events and query answers; tlast marks the
// final result of a request.
// Tick is taken when it is accepted. Set, set-if-active and cancel read the
// channel entry in the accept cycle and write it back from the OP state.
// A query answer is loaded from the OP state once the output register is free;
// it is offered in the same cycle in which the block can take its next request.
// A scan reads one channel entry per cycle from the channel memory while the
// receiver keeps up, writing back a firing channel in the same cycle.
// Each fired event is held back one step so that the last one can carry tlast.
// The block takes one request at a time; tready is high only while idle.
// When the receiver stalls, the result waits in the output register and the
// scan pauses at the channel that needs to hand on an event.
// Reset clears the tick count and marks every channel inactive at once; the
// block is ready in the first cycle after reset.
module periodic_timer_bank_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [3:0] timer_id, [19:4] period,
                                     // [35:20] payload, [39:36] zero
  input  logic [2:0]  s_axis_tuser,  // [2:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [3:0] fired_id, [19:4] fired_payload,
                                     // [20] is_active, [23:21] zero
  output logic        m_axis_tuser,  // [0] resp_kind
  output logic        m_axis_tlast   // last
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_OP    = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0] state_q, state_d;

  logic                            in_accept;
  ptb_pkg::req_e                   in_req;
  logic [ptb_pkg::ID_W-1:0]        in_id;
  logic [ptb_pkg::TIME_W-1:0]      in_per;
  logic [ptb_pkg::PAY_W-1:0]       in_pay;
  logic                            in_id_ok;

  ptb_pkg::req_e                   op_q;
  logic [ptb_pkg::ID_W-1:0]        op_id_q;
  logic                            op_ok_q;
  logic [ptb_pkg::TIME_W-1:0]      op_per_q;
  logic [ptb_pkg::PAY_W-1:0]       op_pay_q;

  logic [ptb_pkg::TIME_W-1:0]      now_q, now_d;
  logic [ptb_pkg::CNT_W-1:0]       rd_cnt_q, rd_cnt_d;
  logic                            ev_vld_q, ev_vld_d;
  logic [ptb_pkg::CH_W-1:0]        ev_idx_q, ev_idx_d;
  logic                            pend_vld_q, pend_vld_d;
  logic [ptb_pkg::CH_W-1:0]        pend_id_q, pend_id_d;
  logic [ptb_pkg::PAY_W-1:0]       pend_pay_q, pend_pay_d;

  ptb_pkg::ram_req_t               ram_req;
  ptb_pkg::entry_t                 rd_data;
  logic [ptb_pkg::TIME_W-1:0]      elapsed;
  logic                            fires;
  logic                            stall;
  logic                            push;
  ptb_pkg::resp_t                  push_data;
  logic                            out_free;

  // Unpack the request.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_req        = ptb_pkg::req_e'(s_axis_tuser);
  assign in_id         = s_axis_tdata[3:0];
  assign in_per        = s_axis_tdata[19:4];
  assign in_pay        = s_axis_tdata[35:20];
  assign in_id_ok      = (32'(in_id) < ptb_pkg::NUM_CHANNELS);

  // Scan compare on the entry last read from the channel memory.
  assign elapsed = now_q - rd_data.start;
  assign fires   = ev_vld_q && (rd_data.period != '0) && (elapsed > rd_data.period);
  assign stall   = fires && pend_vld_q && !out_free;

  // Sequencer: advances the tick count, reads channel entries and writes modified entries back.
  always_comb begin
    state_d    = state_q;
    now_d      = now_q;
    rd_cnt_d   = rd_cnt_q;
    ev_vld_d   = ev_vld_q;
    ev_idx_d   = ev_idx_q;
    pend_vld_d = pend_vld_q;
    pend_id_d  = pend_id_q;
    pend_pay_d = pend_pay_q;
    ram_req    = '0;
    push       = 1'b0;
    push_data  = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_req)
            ptb_pkg::REQ_TICK: begin
              now_d = now_q + 1'b1;
            end
            ptb_pkg::REQ_SCAN: begin
              rd_cnt_d   = '0;
              ev_vld_d   = 1'b0;
              pend_vld_d = 1'b0;
              state_d    = ST_SCAN;
            end
            ptb_pkg::REQ_SET, ptb_pkg::REQ_SET_IF_ACTIVE, ptb_pkg::REQ_CANCEL: begin
              if (in_id_ok) begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = ptb_pkg::CH_W'(in_id);
                state_d         = ST_OP;
              end
            end
            ptb_pkg::REQ_QUERY: begin
              ram_req.rd_en   = in_id_ok;
              ram_req.rd_addr = ptb_pkg::CH_W'(in_id);
              state_d         = ST_OP;
            end
            default: begin
            end
          endcase
        end
      end

      ST_OP: begin
        case (op_q)
          ptb_pkg::REQ_SET: begin
            ram_req.wr_en           = 1'b1;
            ram_req.wr_addr         = ptb_pkg::CH_W'(op_id_q);
            ram_req.wr_data.period  = op_per_q;
            ram_req.wr_data.start   = now_q;
            ram_req.wr_data.payload = op_pay_q;
            state_d                 = ST_IDLE;
          end
          ptb_pkg::REQ_SET_IF_ACTIVE: begin
            ram_req.wr_en           = (rd_data.period != '0);
            ram_req.wr_addr         = ptb_pkg::CH_W'(op_id_q);
            ram_req.wr_data.period  = ptb_pkg::TIME_W'(1);
            ram_req.wr_data.start   = rd_data.start;
            ram_req.wr_data.payload = op_pay_q;
            state_d                 = ST_IDLE;
          end
          ptb_pkg::REQ_CANCEL: begin
            ram_req.wr_en           = 1'b1;
            ram_req.wr_addr         = ptb_pkg::CH_W'(op_id_q);
            ram_req.wr_data.period  = '0;
            ram_req.wr_data.start   = rd_data.start;
            ram_req.wr_data.payload = rd_data.payload;
            state_d                 = ST_IDLE;
          end
          ptb_pkg::REQ_QUERY: begin
            // The answer waits here until the output register is free.
            if (out_free) begin
              push             = 1'b1;
              push_data.kind   = ptb_pkg::RESP_QUERY;
              push_data.id     = op_id_q;
              push_data.active = op_ok_q && (rd_data.period != '0);
              push_data.last   = 1'b1;
              state_d          = ST_IDLE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_SCAN: begin
        if (!stall) begin
          // A firing channel reloads its start; the event before it goes out.
          if (fires) begin
            ram_req.wr_en           = 1'b1;
            ram_req.wr_addr         = ev_idx_q;
            ram_req.wr_data.period  = rd_data.period;
            ram_req.wr_data.start   = now_q;
            ram_req.wr_data.payload = rd_data.payload;
            if (pend_vld_q) begin
              push              = 1'b1;
              push_data.kind    = ptb_pkg::RESP_FIRED;
              push_data.id      = ptb_pkg::ID_W'(pend_id_q);
              push_data.payload = pend_pay_q;
            end
            pend_vld_d = 1'b1;
            pend_id_d  = ev_idx_q;
            pend_pay_d = rd_data.payload;
          end
          // Read the next channel while the current one is compared.
          if (rd_cnt_q < ptb_pkg::CNT_W'(ptb_pkg::NUM_CHANNELS)) begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = rd_cnt_q[ptb_pkg::CH_W-1:0];
            ev_vld_d        = 1'b1;
            ev_idx_d        = rd_cnt_q[ptb_pkg::CH_W-1:0];
            rd_cnt_d        = rd_cnt_q + 1'b1;
          end else begin
            ev_vld_d = 1'b0;
            state_d  = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        // The held event is the final one of the scan.
        if (!pend_vld_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          push              = 1'b1;
          push_data.kind    = ptb_pkg::RESP_FIRED;
          push_data.id      = ptb_pkg::ID_W'(pend_id_q);
          push_data.payload = pend_pay_q;
          push_data.last    = 1'b1;
          pend_vld_d        = 1'b0;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      now_q      <= '0;
      rd_cnt_q   <= '0;
      ev_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      now_q      <= now_d;
      rd_cnt_q   <= rd_cnt_d;
      ev_vld_q   <= ev_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  // Request and pending event payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= in_req;
      op_id_q  <= in_id;
      op_ok_q  <= in_id_ok;
      op_per_q <= in_per;
      op_pay_q <= in_pay;
    end
    ev_idx_q   <= ev_idx_d;
    pend_id_q  <= pend_id_d;
    pend_pay_q <= pend_pay_d;
  end

  ptb_chan_ram u_chan_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  ptb_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .data_i        (push_data),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // A result is only loaded when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> out_free)
    else $error("result loaded into a full output register");

  // A held event exists only during a scan and its final flush.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (state_q == ST_SCAN || state_q == ST_FLUSH))
    else $error("held event outside a scan");

  // The compare stage is only filled while scanning.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_vld_q |-> (state_q == ST_SCAN))
    else $error("compare stage valid outside a scan");

  // Read and write in one cycle always address different channels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req.rd_en && ram_req.wr_en) |-> (ram_req.rd_addr != ram_req.wr_addr))
    else $error("read and write collide on one channel entry");

endmodule
